[hw/rtl/txrd_pkg.sv]
// ----------------------------------------------------------------------------
// txrd_pkg
// Shared types, constants and helpers of the transmit ring DMA block scheduler.
// ----------------------------------------------------------------------------
package txrd_pkg;

  localparam int BUFFER_DEPTH = 256;
  localparam int PTR_W        = $clog2(BUFFER_DEPTH);
  localparam int HALF_DEPTH   = BUFFER_DEPTH / 2;
  localparam int SUM_W        = ((PTR_W > 8) ? PTR_W : 8) + 1;

  typedef logic [PTR_W-1:0] ptr_t;

  localparam logic [1:0] KIND_BYTE     = 2'd0;
  localparam logic [1:0] KIND_COMPLETE = 2'd1;
  localparam logic [1:0] KIND_READ     = 2'd2;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_REJECT = 2'd1;
  localparam logic [1:0] STATUS_NONE   = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] message_length;
    logic       first_byte;
    logic       last_byte;
    logic [7:0] read_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] written_count;
    logic       block_go;
    logic [7:0] block_offset;
    logic [7:0] block_count;
    logic [7:0] read_data;
  } out_item_t;

  typedef struct packed {
    logic exec;
    logic rd_issue;
    logic rd_load;
  } txrd_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } ctrl_state_e;

  // bytes from start up to end, or up to the buffer end when wrapped, capped
  function automatic ptr_t block_size(ptr_t start_ptr, ptr_t end_ptr);
    logic [PTR_W:0] span;
    begin
      if (end_ptr < start_ptr) begin
        span = (PTR_W+1)'(BUFFER_DEPTH) - {1'b0, start_ptr};
      end else begin
        span = {1'b0, end_ptr} - {1'b0, start_ptr};
      end
      if (span > (PTR_W+1)'(HALF_DEPTH)) begin
        span = (PTR_W+1)'(HALF_DEPTH);
      end
      return span[PTR_W-1:0];
    end
  endfunction

endpackage

[hw/rtl/tx_ring_dma_block_scheduler.sv]
// ----------------------------------------------------------------------------
// tx_ring_dma_block_scheduler
// Transmit ring buffer with message admission and DMA block descriptor issue.
// ----------------------------------------------------------------------------
// Every input beat gives exactly one result beat. Message bytes, completions
// and unknown kinds go straight to the output register; a DMA read first
// passes the ring memory's registered read port. A new beat is taken in the
// cycle the previous result is taken, so byte and completion beats sustain
// one per cycle while results are taken and no read is pending. The ring
// memory needs no clearing after reset.
module tx_ring_dma_block_scheduler import txrd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  txrd_cmd_t cmd;

  txrd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_kind_i   (in_item_i.kind),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  txrd_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o)
  );

endmodule

[hw/rtl/txrd_ctrl.sv]
// ----------------------------------------------------------------------------
// txrd_ctrl
// Handshake controller: accepts items, sequences ring reads, owns output valid.
// ----------------------------------------------------------------------------
module txrd_ctrl import txrd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] in_kind_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output txrd_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.exec     = accept && (in_kind_i != KIND_READ);
    cmd_o.rd_issue = accept && (in_kind_i == KIND_READ);
    cmd_o.rd_load  = (state_q == ST_READ);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.rd_issue) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.exec || cmd_o.rd_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/txrd_dpath.sv]
// ----------------------------------------------------------------------------
// txrd_dpath
// Ring memory, pointers, message admission, block descriptors, output register.
// ----------------------------------------------------------------------------
module txrd_dpath import txrd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  txrd_cmd_t cmd_i,
  input  in_item_t  in_item_i,
  output out_item_t out_item_o
);

  logic [7:0] ring_mem [BUFFER_DEPTH];
  logic [7:0] rd_data_q;

  ptr_t       start_q, start_d;
  ptr_t       end_q, end_d;
  ptr_t       shadow_q, shadow_d;
  ptr_t       tsize_q, tsize_d;
  logic       admitted_q, admitted_d;
  logic       rejected_q, rejected_d;
  logic       busy_q, busy_d;
  logic [7:0] slen_q, slen_d;
  logic [7:0] cnt_q, cnt_d;

  out_item_t  out_q, res;
  out_item_t  rd_res;
  logic       wr_en;
  ptr_t       wr_addr;
  ptr_t       occ;
  ptr_t       nsize;
  ptr_t       rd_addr;
  logic [PTR_W:0] start_sum;
  logic       fits;
  logic       issue;

  always_comb begin
    if (end_q < start_q) begin
      occ = ptr_t'(BUFFER_DEPTH - 1) - start_q + end_q + ptr_t'(1);
    end else begin
      occ = end_q - start_q;
    end
  end

  assign fits = (SUM_W'(occ) + SUM_W'(in_item_i.message_length)) < SUM_W'(BUFFER_DEPTH - 1);
  assign start_sum = {1'b0, start_q} + {1'b0, tsize_q};
  assign rd_addr   = ptr_t'(in_item_i.read_offset);

  always_comb begin
    start_d    = start_q;
    end_d      = end_q;
    shadow_d   = shadow_q;
    tsize_d    = tsize_q;
    admitted_d = admitted_q;
    rejected_d = rejected_q;
    busy_d     = busy_q;
    slen_d     = slen_q;
    cnt_d      = cnt_q;
    wr_en      = 1'b0;
    wr_addr    = shadow_q;
    issue      = 1'b0;
    res        = '0;
    res.status = STATUS_NONE;

    if (in_item_i.kind == KIND_BYTE) begin
      if (in_item_i.first_byte) begin
        admitted_d = 1'b0;
        rejected_d = 1'b0;
        if (fits) begin
          admitted_d = 1'b1;
          shadow_d   = end_q;
          slen_d     = in_item_i.message_length;
          cnt_d      = 8'd0;
        end else begin
          rejected_d = 1'b1;
        end
      end
      if (admitted_d) begin
        res.status = STATUS_OK;
        if (cnt_d < slen_d) begin
          wr_en   = 1'b1;
          wr_addr = shadow_d;
          if (shadow_d == ptr_t'(BUFFER_DEPTH - 1)) begin
            shadow_d = '0;
          end else begin
            shadow_d = shadow_d + ptr_t'(1);
          end
          cnt_d = cnt_d + 8'd1;
        end
        if (in_item_i.last_byte) begin
          end_d             = shadow_d;
          res.written_count = cnt_d;
          admitted_d        = 1'b0;
          if (!busy_q && (start_q != end_d)) begin
            issue = 1'b1;
          end
        end
      end else if (rejected_d) begin
        res.status = STATUS_REJECT;
        if (in_item_i.last_byte) begin
          rejected_d = 1'b0;
        end
      end
    end else if (in_item_i.kind == KIND_COMPLETE) begin
      if (busy_q) begin
        res.status = STATUS_OK;
        if (start_sum >= (PTR_W+1)'(BUFFER_DEPTH)) begin
          start_d = '0;
        end else begin
          start_d = start_sum[PTR_W-1:0];
        end
        if (start_d != end_q) begin
          issue = 1'b1;
        end else begin
          busy_d = 1'b0;
        end
      end
    end

    nsize = block_size(start_d, end_d);
    if (issue) begin
      tsize_d          = nsize;
      busy_d           = 1'b1;
      res.block_go     = 1'b1;
      res.block_offset = 8'(start_d);
      res.block_count  = 8'(nsize);
    end
  end

  always_comb begin
    rd_res           = '0;
    rd_res.status    = STATUS_OK;
    rd_res.read_data = rd_data_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      ring_mem[wr_addr] <= in_item_i.data_byte;
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= ring_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_q <= res;
    end else if (cmd_i.rd_load) begin
      out_q <= rd_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q    <= '0;
      end_q      <= '0;
      shadow_q   <= '0;
      tsize_q    <= '0;
      admitted_q <= 1'b0;
      rejected_q <= 1'b0;
      busy_q     <= 1'b0;
      slen_q     <= 8'd0;
      cnt_q      <= 8'd0;
    end else if (cmd_i.exec) begin
      start_q    <= start_d;
      end_q      <= end_d;
      shadow_q   <= shadow_d;
      tsize_q    <= tsize_d;
      admitted_q <= admitted_d;
      rejected_q <= rejected_d;
      busy_q     <= busy_d;
      slen_q     <= slen_d;
      cnt_q      <= cnt_d;
    end
  end

  assign out_item_o = out_q;

endmodule
